FILE: rtl/rlcs_pkg.sv
// Shared types, constants and helper functions for the RGB LED chain serializer.
// Used by every module of the block; depends on nothing else.
package rlcs_pkg;

  localparam int REQ_W        = 2;
  localparam int IDX_W        = 8;
  localparam int COLOR_W      = 24;
  localparam int LED_CNT_W    = 7;
  localparam int TICK_W       = 8;
  localparam int BIT_POS_W    = 5;
  localparam int BITS_PER_LED = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int DEF_MAX_LEDS = 64;

  // Request codes on the input channel.
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd4;

  localparam logic [LED_CNT_W-1:0] RST_LED_COUNT = 7'd0;
  localparam logic [TICK_W-1:0]    RST_ONE_HIGH  = 8'd33;
  localparam logic [TICK_W-1:0]    RST_ONE_LOW   = 8'd18;
  localparam logic [TICK_W-1:0]    RST_ZERO_HIGH = 8'd12;
  localparam logic [TICK_W-1:0]    RST_ZERO_LOW  = 8'd45;

  // Operation after classification by the front end.
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_WRITE_REJ,
    OP_START,
    OP_TICK,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } q_item_t;

  typedef struct packed {
    logic [LED_CNT_W-1:0] led_count;
    logic [TICK_W-1:0]    one_high;
    logic [TICK_W-1:0]    one_low;
    logic [TICK_W-1:0]    zero_high;
    logic [TICK_W-1:0]    zero_low;
  } cfg_t;

  // Bytes go out low byte first, each byte MSB first.
  function automatic logic word_bit(input logic [COLOR_W-1:0] word,
                                    input logic [BIT_POS_W-1:0] pos);
    logic [BIT_POS_W-1:0] sel;
    sel = {pos[4:3], ~pos[2:0]};
    if (pos >= BIT_POS_W'(BITS_PER_LED)) begin
      return 1'b0;
    end
    return word[sel];
  endfunction

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

FILE: rtl/rlcs_front.sv
// Front end of the LED chain serializer: decodes each request and checks
// write indexes against the LED count. Depends on rlcs_pkg.
module rlcs_front #(
  parameter int MAX_LEDS = rlcs_pkg::DEF_MAX_LEDS
) (
  input  logic [rlcs_pkg::REQ_W-1:0]   req_type,
  input  logic [rlcs_pkg::IDX_W-1:0]   pixel_index,
  input  logic [rlcs_pkg::COLOR_W-1:0] pixel_color,
  input  rlcs_pkg::cfg_t               cfg,
  output rlcs_pkg::q_item_t            item
);
  import rlcs_pkg::*;

  logic idx_ok;

  always_comb begin
    idx_ok = (32'(pixel_index) < MAX_LEDS) &&
             ({1'b0, pixel_index} < {2'b00, cfg.led_count});
    item.idx   = pixel_index;
    item.color = pixel_color;
    unique case (req_type)
      REQ_WRITE: item.op = idx_ok ? OP_WRITE : OP_WRITE_REJ;
      REQ_START: item.op = OP_START;
      REQ_TICK:  item.op = OP_TICK;
      default:   item.op = OP_BAD;
    endcase
  end

endmodule

FILE: rtl/rlcs_queue.sv
// Short request queue between the front end and the frame engine.
// Depends on rlcs_pkg for the item type and depth.
module rlcs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rlcs_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output rlcs_pkg::q_item_t head
);
  import rlcs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/rlcs_store.sv
// Pixel color memory with per-entry valid bits and a registered read port.
// A write to the address being read is forwarded. Depends on rlcs_pkg.
module rlcs_store #(
  parameter int  MAX_LEDS = rlcs_pkg::DEF_MAX_LEDS,
  localparam int AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [rlcs_pkg::COLOR_W-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr,
  output logic [rlcs_pkg::COLOR_W-1:0] rd_word
);
  import rlcs_pkg::*;

  logic [COLOR_W-1:0] mem_r [MAX_LEDS];
  logic [MAX_LEDS-1:0] vld_r;
  logic [COLOR_W-1:0] rd_data_r;
  logic               rd_vld_r;
  logic               byp_r;
  logic [COLOR_W-1:0] byp_data_r;

  // Entries never written since reset read as zero.
  assign rd_word = byp_r ? byp_data_r : (rd_vld_r ? rd_data_r : '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r  <= mem_r[rd_addr];
    byp_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
      byp_r    <= wr_en && (wr_addr == rd_addr);
    end
  end

endmodule

FILE: rtl/rlcs_engine.sv
// Frame engine: executes queued requests, owns the bit timing state and the
// result register, and keeps the next LED's color prefetched. Depends on rlcs_pkg.
module rlcs_engine #(
  parameter int  MAX_LEDS = rlcs_pkg::DEF_MAX_LEDS,
  localparam int AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rlcs_pkg::cfg_t               cfg,
  input  logic                         q_not_empty,
  input  rlcs_pkg::q_item_t            q_head,
  output logic                         q_pop,
  output logic                         st_wr_en,
  output logic [AW-1:0]                st_wr_addr,
  output logic [rlcs_pkg::COLOR_W-1:0] st_wr_data,
  output logic [AW-1:0]                st_rd_addr,
  input  logic [rlcs_pkg::COLOR_W-1:0] st_rd_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic                         out_serial_out,
  output logic                         out_busy_res,
  output logic                         out_frame_done
);
  import rlcs_pkg::*;

  logic                   sending_r, sending_nxt;
  logic [LED_CNT_W-1:0]   led_pos_r, led_pos_nxt;
  logic [BIT_POS_W-1:0]   bit_pos_r, bit_pos_nxt;
  logic                   high_r, high_nxt;
  logic [TICK_W-1:0]      ticks_r, ticks_nxt;
  logic [COLOR_W-1:0]     word_r, word_nxt;

  logic                   out_valid_r;
  logic                   status_r, level_r, busy_r, done_r;
  logic                   status_c, level_c, done_c;

  logic [LED_CNT_W-1:0]   active_cnt;
  logic [LED_CNT_W:0]     next_led;
  logic [LED_CNT_W:0]     prefetch_led;
  logic                   cur_bit;
  logic                   new_bit;

  assign q_pop          = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_serial_out = level_r;
  assign out_busy_res   = busy_r;
  assign out_frame_done = done_r;

  assign st_wr_addr = AW'(q_head.idx);
  assign st_wr_data = q_head.color;

  always_comb begin
    active_cnt = (32'(cfg.led_count) > MAX_LEDS) ? LED_CNT_W'(MAX_LEDS) : cfg.led_count;
    cur_bit    = word_bit(word_r, bit_pos_r);
    next_led   = {1'b0, led_pos_r} + (LED_CNT_W + 1)'(1);
    new_bit    = 1'b0;

    sending_nxt = sending_r;
    led_pos_nxt = led_pos_r;
    bit_pos_nxt = bit_pos_r;
    high_nxt    = high_r;
    ticks_nxt   = ticks_r;
    word_nxt    = word_r;
    status_c    = 1'b0;
    level_c     = sending_r & high_r;
    done_c      = 1'b0;
    st_wr_en    = 1'b0;

    if (q_pop) begin
      unique case (q_head.op)
        OP_WRITE: begin
          if (sending_r) begin
            status_c = 1'b1;
          end else begin
            st_wr_en = 1'b1;
          end
        end
        OP_START: begin
          if (sending_r) begin
            status_c = 1'b1;
          end else if (active_cnt == '0) begin
            done_c = 1'b1;
          end else begin
            // While idle the prefetched word is always LED zero.
            sending_nxt = 1'b1;
            led_pos_nxt = '0;
            bit_pos_nxt = '0;
            word_nxt    = st_rd_word;
            new_bit     = 1'b1;
          end
        end
        OP_TICK: begin
          if (sending_r) begin
            if (ticks_r > TICK_W'(1)) begin
              ticks_nxt = ticks_r - TICK_W'(1);
            end else if (high_r) begin
              high_nxt  = 1'b0;
              ticks_nxt = at_least_one(cur_bit ? cfg.one_low : cfg.zero_low);
            end else if (bit_pos_r == BIT_POS_W'(BITS_PER_LED - 1)) begin
              bit_pos_nxt = '0;
              if (next_led >= {1'b0, active_cnt}) begin
                sending_nxt = 1'b0;
                led_pos_nxt = '0;
                high_nxt    = 1'b0;
                ticks_nxt   = '0;
                done_c      = 1'b1;
              end else begin
                led_pos_nxt = LED_CNT_W'(next_led);
                word_nxt    = st_rd_word;
                new_bit     = 1'b1;
              end
            end else begin
              bit_pos_nxt = bit_pos_r + BIT_POS_W'(1);
              new_bit     = 1'b1;
            end
          end
        end
        OP_WRITE_REJ, OP_BAD: begin
          status_c = 1'b1;
        end
        default: begin
          status_c = 1'b1;
        end
      endcase
    end

    // The start item itself shows a low line.
    if (q_pop && q_head.op == OP_START && !sending_r) begin
      level_c = 1'b0;
    end

    if (new_bit) begin
      high_nxt  = 1'b1;
      ticks_nxt = at_least_one(word_bit(word_nxt, bit_pos_nxt) ? cfg.one_high
                                                               : cfg.zero_high);
    end

    // Keep the color of the LED after the one being sent ready in the store's
    // read register; writes only happen while idle, when that is LED zero.
    prefetch_led = {1'b0, led_pos_nxt} + (LED_CNT_W + 1)'(1);
    if (sending_nxt && (32'(prefetch_led) < MAX_LEDS)) begin
      st_rd_addr = AW'(prefetch_led);
    end else begin
      st_rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r   <= 1'b0;
      led_pos_r   <= '0;
      bit_pos_r   <= '0;
      high_r      <= 1'b0;
      ticks_r     <= '0;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sending_r <= sending_nxt;
      led_pos_r <= led_pos_nxt;
      bit_pos_r <= bit_pos_nxt;
      high_r    <= high_nxt;
      ticks_r   <= ticks_nxt;
      word_r    <= word_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_c;
      level_r  <= level_c;
      busy_r   <= sending_nxt;
      done_r   <= done_c;
    end
  end

endmodule

FILE: rtl/rgb_led_chain_serializer.sv
// One-wire serializer for a chain of addressable RGB LEDs.
// A request accepted into the request queue is executed by the frame engine, and its result is registered.
// Throughput: one request per cycle while out_stall is low, set by the frame engine step;
// the four-entry request queue absorbs output stalls.
// Reset (synchronous, rst_n low): idle, pixel store reads as zero, timing
// registers at their defaults, queue and result register empty.
module rgb_led_chain_serializer #(
  parameter int MAX_LEDS = rlcs_pkg::DEF_MAX_LEDS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rlcs_pkg::REQ_W-1:0]      in_req_type,
  input  logic [rlcs_pkg::IDX_W-1:0]      in_pixel_index,
  input  logic [rlcs_pkg::COLOR_W-1:0]    in_pixel_color,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_status,
  output logic                            out_serial_out,
  output logic                            out_busy_res,
  output logic                            out_frame_done,
  input  logic                            cfg_we,
  input  logic [rlcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rlcs_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  cfg_t               cfg_r;
  q_item_t            front_item;
  q_item_t            q_head;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;
  logic               st_wr_en;
  logic [AW-1:0]      st_wr_addr;
  logic [COLOR_W-1:0] st_wr_data;
  logic [AW-1:0]      st_rd_addr;
  logic [COLOR_W-1:0] st_rd_word;

  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count <= RST_LED_COUNT;
      cfg_r.one_high  <= RST_ONE_HIGH;
      cfg_r.one_low   <= RST_ONE_LOW;
      cfg_r.zero_high <= RST_ZERO_HIGH;
      cfg_r.zero_low  <= RST_ZERO_LOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LED_COUNT: cfg_r.led_count <= cfg_wdata[LED_CNT_W-1:0];
        REG_ONE_HIGH:  cfg_r.one_high  <= cfg_wdata;
        REG_ONE_LOW:   cfg_r.one_low   <= cfg_wdata;
        REG_ZERO_HIGH: cfg_r.zero_high <= cfg_wdata;
        REG_ZERO_LOW:  cfg_r.zero_low  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rlcs_front #(.MAX_LEDS(MAX_LEDS)) u_front (
    .req_type    (in_req_type),
    .pixel_index (in_pixel_index),
    .pixel_color (in_pixel_color),
    .cfg         (cfg_r),
    .item        (front_item)
  );

  rlcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rlcs_store #(.MAX_LEDS(MAX_LEDS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_word (st_rd_word)
  );

  rlcs_engine #(.MAX_LEDS(MAX_LEDS)) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .st_wr_en       (st_wr_en),
    .st_wr_addr     (st_wr_addr),
    .st_wr_data     (st_wr_data),
    .st_rd_addr     (st_rd_addr),
    .st_rd_word     (st_rd_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_serial_out (out_serial_out),
    .out_busy_res   (out_busy_res),
    .out_frame_done (out_frame_done)
  );

endmodule
